// ----- src/svf_pkg.sv -----
// ----------------------------------------------------------------------------
// svf_pkg: shared types and constants for the state variable filter
// Widths, shift amounts, register indexes and the multiply unit's control word.
// ----------------------------------------------------------------------------
package svf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int STATE_W  = 32;
	localparam int COEFF_W  = 9;
	localparam int DAMP_W   = 16;
	localparam int MODE_W   = 2;
	localparam int MUL_B_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int DAMP_SHIFT = 14;
	localparam int FREQ_SHIFT = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_COEFF    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_MODE = 2'd2;

	// response select codes
	localparam logic [MODE_W-1:0] MODE_HIGHPASS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOWPASS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BANDPASS = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOTCH    = 2'd3;

	typedef struct packed {
		logic en;          // load a new product
		logic damp_shift;  // 1: shift by DAMP_SHIFT, 0: by FREQ_SHIFT
	} mul_ctl_t;

endpackage

// ----- src/svf_mul.sv -----
// ----------------------------------------------------------------------------
// svf_mul: shared multiply and scale unit
// Registers the low 32 bits of a 32 x 16 product and presents it arithmetically
// shifted right by the amount chosen with the operands.
// ----------------------------------------------------------------------------
module svf_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  svf_pkg::mul_ctl_t                   ctl,
	input  logic [svf_pkg::STATE_W-1:0]         op_a,
	input  logic [svf_pkg::MUL_B_W-1:0]         op_b,
	output logic signed [svf_pkg::STATE_W-1:0]  res
);

	logic [svf_pkg::STATE_W-1:0]                  full_prod;
	logic [svf_pkg::STATE_W-1:0]                  prod_q;
	logic                                         damp_shift_q;

	// only the low 32 bits of the product matter: the states wrap
	assign full_prod = op_a * svf_pkg::STATE_W'(op_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damp_shift_q <= 1'b0;
		end else if (ctl.en) begin
			damp_shift_q <= ctl.damp_shift;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= full_prod;
		end
	end

	assign res = damp_shift_q ? ($signed(prod_q) >>> svf_pkg::DAMP_SHIFT)
	                          : ($signed(prod_q) >>> svf_pkg::FREQ_SHIFT);

endmodule

// ----- src/svf_seq.sv -----
// ----------------------------------------------------------------------------
// svf_seq: filter sequencer and integrator states
// Steps one sample through high, band and low updates on the shared multiplier.
// ----------------------------------------------------------------------------
module svf_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [svf_pkg::SAMPLE_W-1:0]       sample,
	input  logic [svf_pkg::COEFF_W-1:0]        freq_coeff,
	input  logic [svf_pkg::DAMP_W-1:0]         damping,
	input  logic [svf_pkg::MODE_W-1:0]         response_mode,
	input  logic                               res_take,
	output logic                               idle,
	output logic                               res_valid,
	output logic [svf_pkg::SAMPLE_W-1:0]       res_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HIGH = 3'd1;
	localparam logic [2:0] ST_MULH = 3'd2;
	localparam logic [2:0] ST_BAND = 3'd3;
	localparam logic [2:0] ST_MULB = 3'd4;
	localparam logic [2:0] ST_LOW  = 3'd5;

	logic [2:0]                         state_q;
	logic [svf_pkg::STATE_W-1:0]        band_q;
	logic [svf_pkg::STATE_W-1:0]        low_q;
	logic [svf_pkg::STATE_W-1:0]        high_q;
	logic signed [svf_pkg::SAMPLE_W-1:0] x_q;

	svf_pkg::mul_ctl_t                  mul_ctl;
	logic [svf_pkg::STATE_W-1:0]        mul_a;
	logic [svf_pkg::MUL_B_W-1:0]        mul_b;
	logic signed [svf_pkg::STATE_W-1:0] mul_res;
	logic [svf_pkg::STATE_W-1:0]        low_new;
	logic [svf_pkg::STATE_W-1:0]        sel;

	svf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.res    (mul_res)
	);

	always_comb begin
		mul_ctl.en         = 1'b0;
		mul_ctl.damp_shift = 1'b0;
		mul_a              = band_q;
		mul_b              = svf_pkg::MUL_B_W'(freq_coeff);
		unique case (state_q)
			ST_IDLE: begin
				// damping * band does not depend on the sample: start it on the transfer
				mul_ctl.en         = start;
				mul_ctl.damp_shift = 1'b1;
				mul_b              = damping;
			end
			ST_MULH: begin
				mul_ctl.en = 1'b1;
				mul_a      = high_q;
			end
			ST_MULB: begin
				mul_ctl.en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign low_new = low_q + svf_pkg::STATE_W'(mul_res);

	always_comb begin
		unique case (response_mode)
			svf_pkg::MODE_HIGHPASS: sel = high_q;
			svf_pkg::MODE_LOWPASS:  sel = low_new;
			svf_pkg::MODE_BANDPASS: sel = band_q;
			default:                sel = high_q + low_new;
		endcase
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_LOW);
	assign res_data  = sel[svf_pkg::SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			band_q  <= '0;
			low_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_HIGH;
				ST_HIGH: state_q <= ST_MULH;
				ST_MULH: state_q <= ST_BAND;
				ST_BAND: begin
					band_q  <= band_q + svf_pkg::STATE_W'(mul_res);
					state_q <= ST_MULB;
				end
				ST_MULB: state_q <= ST_LOW;
				ST_LOW: begin
					// hold until the output register can take the result
					if (res_take) begin
						low_q   <= low_new;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (idle && start) begin
			x_q <= sample;
		end
		if (state_q == ST_HIGH) begin
			high_q <= svf_pkg::STATE_W'(x_q) - low_q - svf_pkg::STATE_W'(mul_res);
		end
	end

endmodule

// ----- src/state_variable_filter_core.sv -----
// ----------------------------------------------------------------------------
// state_variable_filter_core: Chamberlin state variable filter
// Two-integrator filter on 16-bit samples with selectable response.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | tdata[15:0] sample_in
//  m_*      | out       | tdata[15:0] sample_out
//  cfg_*    | in        | cfg_index[1:0], cfg_data[15:0]
//
// Each sample passes through the high, band and low steps before its result reaches
// the output register, steps set by three dependent products on one 32 x 16 multiplier;
// the next sample is taken only once the sequencer is back in idle.
// s_tready is high only while the sequencer is idle; a result may wait in the
// output register while the next sample is taken in. Reset clears both integrators,
// the registers and the output valid; a stalled output holds the last step.
module state_variable_filter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [svf_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] sample_in
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [svf_pkg::SAMPLE_W-1:0]        m_tdata,   // [15:0] sample_out
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [svf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [svf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [svf_pkg::COEFF_W-1:0]  freq_coeff_q;
	logic [svf_pkg::DAMP_W-1:0]   damping_q;
	logic [svf_pkg::MODE_W-1:0]   response_mode_q;
	logic                         m_tvalid_q;
	logic [svf_pkg::SAMPLE_W-1:0] m_tdata_q;
	logic                         seq_idle;
	logic                         res_valid;
	logic                         res_take;
	logic [svf_pkg::SAMPLE_W-1:0] res_data;

	assign cfg_ready = 1'b1;
	assign s_tready  = seq_idle;
	assign res_take  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	svf_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (s_tvalid && seq_idle),
		.sample        (s_tdata),
		.freq_coeff    (freq_coeff_q),
		.damping       (damping_q),
		.response_mode (response_mode_q),
		.res_take      (res_take),
		.idle          (seq_idle),
		.res_valid     (res_valid),
		.res_data      (res_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_coeff_q    <= '0;
			damping_q       <= '0;
			response_mode_q <= svf_pkg::MODE_HIGHPASS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				svf_pkg::REG_FREQ_COEFF:    freq_coeff_q    <= cfg_data[svf_pkg::COEFF_W-1:0];
				svf_pkg::REG_DAMPING:       damping_q       <= cfg_data[svf_pkg::DAMP_W-1:0];
				svf_pkg::REG_RESPONSE_MODE: response_mode_q <= cfg_data[svf_pkg::MODE_W-1:0];
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			m_tdata_q <= res_data;
		end
	end

	// a sample transfer starts the sequence, so the input side closes next cycle
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted twice in a row");

	// no result can appear the cycle after a sample transfer
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// a new result is only loaded while the sequencer is in its last step
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result loaded while idle");

endmodule

// ----- bench/svf_response_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svf_response_check: response predictor and comparator for the filter core
// Watches the sample, result and register channels, runs its own copy of the
// two integrators on every accepted sample and compares each result transfer
// against the oldest predicted sample.
// ----------------------------------------------------------------------------
module svf_response_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [svf_pkg::SAMPLE_W-1:0]   s_tdata,    // [15:0] sample_in
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [svf_pkg::SAMPLE_W-1:0]   m_tdata,    // [15:0] sample_out
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [svf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [svf_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             pending
);

	logic [svf_pkg::COEFF_W-1:0]         coeff_q8;
	logic [svf_pkg::DAMP_W-1:0]          damp_q14;
	logic [svf_pkg::MODE_W-1:0]          resp_sel;
	logic signed [svf_pkg::STATE_W-1:0]  band_acc;
	logic signed [svf_pkg::STATE_W-1:0]  low_acc;
	logic [svf_pkg::SAMPLE_W-1:0]        expected_samples[$];
	int                                  result_count;

	task automatic report(input string what, input logic [svf_pkg::SAMPLE_W-1:0] got,
			input logic [svf_pkg::SAMPLE_W-1:0] want);
		$display("[%0t] result %0d: %s: got %h, expected %h", $realtime, result_count,
			what, got, want);
		mismatches++;
	endtask

	// One filter update; products wrap to 32 bits before the arithmetic shift.
	function automatic logic [svf_pkg::SAMPLE_W-1:0] filter_step(
			input logic signed [svf_pkg::SAMPLE_W-1:0] x);
		logic signed [svf_pkg::STATE_W-1:0] xin, high, band, low, sel, term;
		logic [svf_pkg::STATE_W-1:0]        prod;
		xin  = x;
		prod = {16'b0, damp_q14} * band_acc;
		term = $signed(prod) >>> svf_pkg::DAMP_SHIFT;
		high = xin - low_acc - term;
		prod = high * {23'b0, coeff_q8};
		term = $signed(prod) >>> svf_pkg::FREQ_SHIFT;
		band = band_acc + term;
		prod = {23'b0, coeff_q8} * band;
		term = $signed(prod) >>> svf_pkg::FREQ_SHIFT;
		low  = low_acc + term;
		band_acc = band;
		low_acc  = low;
		case (resp_sel)
			svf_pkg::MODE_HIGHPASS: sel = high;
			svf_pkg::MODE_LOWPASS:  sel = low;
			svf_pkg::MODE_BANDPASS: sel = band;
			default:                sel = high + low;
		endcase
		return sel[svf_pkg::SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [svf_pkg::SAMPLE_W-1:0] want;
		if (!arst_n) begin
			coeff_q8     = '0;
			damp_q14     = '0;
			resp_sel     = svf_pkg::MODE_HIGHPASS;
			band_acc     = '0;
			low_acc      = '0;
			result_count = 0;
			mismatches   = 0;
			expected_samples.delete();
			pending <= 0;
		end else begin
			// compare first: a result never belongs to a sample taken at the same edge
			if (m_tvalid && m_tready) begin
				if (expected_samples.size() == 0) begin
					report("no sample outstanding", m_tdata, 'x);
				end else begin
					want = expected_samples.pop_front();
					if (m_tdata !== want)
						report("sample_out", m_tdata, want);
				end
				result_count++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					svf_pkg::REG_FREQ_COEFF:    coeff_q8 = cfg_data[svf_pkg::COEFF_W-1:0];
					svf_pkg::REG_DAMPING:       damp_q14 = cfg_data[svf_pkg::DAMP_W-1:0];
					svf_pkg::REG_RESPONSE_MODE: resp_sel = cfg_data[svf_pkg::MODE_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_samples.push_back(filter_step(s_tdata));
			pending <= expected_samples.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for state_variable_filter_core
// Drives register writes, and samples with random gaps, against output stalls;
// a directed opening covers the extremes, every response and wraparound,
// then random phases sweep coefficient, damping and mode settings.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SAMPLES = 125;
	localparam logic [svf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [svf_pkg::SAMPLE_W-1:0]   s_tdata;    // [15:0] sample_in
	logic                           m_tvalid;
	logic                           m_tready;
	logic [svf_pkg::SAMPLE_W-1:0]   m_tdata;    // [15:0] sample_out
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [svf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [svf_pkg::CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int pending;
	int cycle_count = 0;
	bit quiet;

	state_variable_filter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	svf_response_check u_response_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// result side: random stall before each transfer, none while quiet
	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_sample(input logic [svf_pkg::SAMPLE_W-1:0] value);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid and hold until every predicted sample has come back
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [svf_pkg::CFG_IDX_W-1:0] idx,
			input logic [svf_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [svf_pkg::CFG_DATA_W-1:0] coeff_d, damp_d, mode_d,
			input bit stray);
		write_reg(svf_pkg::REG_FREQ_COEFF, coeff_d);
		write_reg(svf_pkg::REG_DAMPING, damp_d);
		write_reg(svf_pkg::REG_RESPONSE_MODE, mode_d);
		if (stray)
			write_reg(REG_UNUSED, svf_pkg::CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [svf_pkg::SAMPLE_W-1:0] pick_sample();
		logic [svf_pkg::SAMPLE_W-1:0] v;
		case ($urandom_range(0, 9))
			0:       v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			1, 2, 3: v = svf_pkg::SAMPLE_W'($urandom_range(0, 1024) - 512);
			default: v = svf_pkg::SAMPLE_W'($urandom);
		endcase
		return v;
	endfunction

	initial begin
		logic [svf_pkg::CFG_DATA_W-1:0] coeff_d, damp_d, mode_d;
		logic [svf_pkg::MODE_W-1:0]     mode;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= svf_pkg::REG_FREQ_COEFF;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		quiet = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero coefficient, highpass passes the sample through
		send_sample(16'h0000);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);

		// wide writes truncate: full coefficient, full damping, notch
		hold_until_drained();
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		repeat (3) send_sample(16'h7FFF);
		repeat (3) send_sample(16'h8000);

		hold_until_drained();
		configure(16'd128, 16'd23170, {14'h0, svf_pkg::MODE_LOWPASS}, 1'b0);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		send_sample(16'h7FFF);
		send_sample(16'h8000);

		hold_until_drained();
		configure(16'd40, 16'd16384, {14'h0, svf_pkg::MODE_BANDPASS}, 1'b0);
		send_sample(16'd1000);
		send_sample(-16'sd1000);
		send_sample(16'd0);
		send_sample(16'd12345);

		hold_until_drained();
		configure(16'd0, 16'd0, {14'h0, svf_pkg::MODE_HIGHPASS}, 1'b0);
		send_sample(16'h1234);
		send_sample(16'hEDCB);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			hold_until_drained();
			quiet = (p % 3 == 1);
			case ($urandom_range(0, 4))
				0:       coeff_d = 16'd0;
				1:       coeff_d = 16'd511;
				2:       coeff_d = svf_pkg::CFG_DATA_W'($urandom);
				default: coeff_d = svf_pkg::CFG_DATA_W'($urandom_range(1, 200));
			endcase
			case ($urandom_range(0, 3))
				0:       damp_d = 16'd0;
				1:       damp_d = 16'hFFFF;
				2:       damp_d = svf_pkg::CFG_DATA_W'($urandom);
				default: damp_d = svf_pkg::CFG_DATA_W'($urandom_range(8000, 32768));
			endcase
			case (p % 4)
				0:       mode = svf_pkg::MODE_HIGHPASS;
				1:       mode = svf_pkg::MODE_LOWPASS;
				2:       mode = svf_pkg::MODE_BANDPASS;
				default: mode = svf_pkg::MODE_NOTCH;
			endcase
			mode_d = {14'($urandom_range(0, 16383)), mode};
			configure(coeff_d, damp_d, mode_d, $urandom_range(0, 2) == 0);
			for (int i = 0; i < PHASE_SAMPLES; i++) begin
				send_sample(pick_sample());
				if (i == PHASE_SAMPLES / 2 && p % 2 == 0)
					hold_until_drained();
			end
		end

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/svf_pkg.sv
src/svf_mul.sv
src/svf_seq.sv
src/state_variable_filter_core.sv
bench/svf_response_check.sv
bench/testbench.sv
